// ----- rtl/brapx_pkg.sv -----
// ----------------------------------------------------------------------------
// brapx_pkg: shared types and constants of the rational approximation block
// Widths of the fixed-point input, the denominator limit and the arithmetic
// operands used by the divider, the multiply-add unit and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package brapx_pkg;

  localparam int FRAC_BITS = 16;
  localparam int INT_BITS  = 16;
  localparam int VAL_W     = INT_BITS + FRAC_BITS;
  localparam int LIM_W     = 16;
  localparam int NUM_W     = 32;
  localparam int P_W       = FRAC_BITS;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int A_W       = Q_W;
  localparam int MAC_W     = A_W + LIM_W;
  localparam int CNT_W     = $clog2(Q_W);

  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(32);

  typedef struct packed {
    logic           done;
    logic [A_W-1:0] quo;
    logic [P_W-1:0] rem;
  } div_res_t;

endpackage

`default_nettype wire

// ----- rtl/brapx_div.sv -----
// ----------------------------------------------------------------------------
// brapx_div: serial restoring divider
// Produces one quotient bit per cycle; quotient and remainder hold until the
// next start.
// ----------------------------------------------------------------------------
`default_nettype none

module brapx_div
  import brapx_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [Q_W-1:0] dividend,
  input  wire logic [P_W-1:0] divisor,
  output div_res_t            res
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [Q_W-1:0]   dvd_r;
  logic [P_W-1:0]   rem_r;
  logic [P_W-1:0]   dvs_r;

  logic [P_W:0]     trial;
  logic             take;
  logic [P_W-1:0]   rem_nxt;

  assign trial   = {rem_r, dvd_r[Q_W-1]};
  assign take    = trial >= {1'b0, dvs_r};
  assign rem_nxt = take ? P_W'(trial - {1'b0, dvs_r}) : trial[P_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      cnt_r <= CNT_W'(Q_W - 1);
    end else if (busy_r) begin
      dvd_r <= {dvd_r[Q_W-2:0], take};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign res.done = done_r;
  assign res.quo  = dvd_r;
  assign res.rem  = rem_r;

endmodule

`default_nettype wire

// ----- rtl/brapx_mac.sv -----
// ----------------------------------------------------------------------------
// brapx_mac: shared multiply-add unit
// Registers acc + a * b; used for both convergent recurrences in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module brapx_mac
  import brapx_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] acc,
  input  wire logic [A_W-1:0]   mul_a,
  input  wire logic [NUM_W-1:0] mul_b,
  output logic      [MAC_W-1:0] res
);

  logic [A_W+NUM_W-1:0] prod;
  logic [MAC_W-1:0]     res_r;

  assign prod = {{NUM_W{1'b0}}, mul_a} * {{A_W{1'b0}}, mul_b};

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= MAC_W'(acc) + prod[MAC_W-1:0];
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ----- rtl/best_rational_approximation.sv -----
// ----------------------------------------------------------------------------
// best_rational_approximation: continued-fraction best rational approximation
// Expands an unsigned Q16.16 value by an exact Euclidean algorithm and returns
// the last convergent whose denominator stays within the configured limit.
//
//   Port group  Dir  Contents
//   in_*        in   value_fixed [31:0]
//   out_*       out  numerator [31:0], denominator [47:32]
//   cfg_*       in   max_denominator [15:0]
//
// Each continued-fraction term passes through the serial divider, a denominator
// multiply-add and compare, and an update; the serial divider takes most of it.
// An integer part above the limit goes straight to the final state, and an
// integer input goes there after one check of its fraction part.
// Reset is synchronous and active low and restores a limit of 32.
// The input side is ready again once a result sits in the output register;
// the next result waits in the final state until that register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module best_rational_approximation
  import brapx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [VAL_W-1:0]  in_tdata,   // value_fixed
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [NUM_W+LIM_W-1:0] out_tdata,  // numerator, denominator
  input  wire logic              cfg_we,
  input  wire logic [LIM_W-1:0]  cfg_wdata   // max_denominator
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_MULD  = 3'd3;
  localparam logic [2:0] ST_CMPD  = 3'd4;
  localparam logic [2:0] ST_UPD   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [LIM_W-1:0] max_den_r;
  logic [LIM_W-1:0] lim_r;
  logic [Q_W-1:0]   q_r;
  logic [P_W-1:0]   p_r;
  logic [NUM_W-1:0] n0_r, n1_r;
  logic [LIM_W-1:0] d0_r, d1_r, d2_r;
  logic             out_valid_r;
  logic [NUM_W-1:0] out_num_r;
  logic [LIM_W-1:0] out_den_r;

  logic             in_acc;
  logic [LIM_W-1:0] lim_in;
  logic [LIM_W-1:0] ipart;
  logic             div_start;
  div_res_t         div_res;
  logic             mac_en;
  logic [NUM_W-1:0] mac_acc, mac_b;
  logic [MAC_W-1:0] mac_res;
  logic             d2_over;
  logic             out_load;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign lim_in    = (max_den_r == '0) ? LIM_W'(1) : max_den_r;
  assign ipart     = in_tdata[VAL_W-1:FRAC_BITS];
  assign div_start = (state_r == ST_CHECK) && (p_r != '0);
  assign d2_over   = mac_res > MAC_W'(lim_r);
  assign mac_en    = (state_r == ST_MULD) || ((state_r == ST_CMPD) && !d2_over);
  assign mac_acc   = (state_r == ST_MULD) ? NUM_W'(d0_r) : n0_r;
  assign mac_b     = (state_r == ST_MULD) ? NUM_W'(d1_r) : n1_r;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  brapx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (q_r),
    .divisor  (p_r),
    .res      (div_res)
  );

  brapx_mac u_mac (
    .clk   (clk),
    .en    (mac_en),
    .acc   (mac_acc),
    .mul_a (div_res.quo),
    .mul_b (mac_b),
    .res   (mac_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (ipart > lim_in) ? ST_DONE : ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = (p_r == '0) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_nxt = ST_MULD;
        end
      end
      ST_MULD: state_nxt = ST_CMPD;
      ST_CMPD: state_nxt = d2_over ? ST_DONE : ST_UPD;
      ST_UPD:  state_nxt = ST_CHECK;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_den_r   <= LIM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        max_den_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      lim_r <= lim_in;
      q_r   <= Q_W'(1) << FRAC_BITS;
      p_r   <= in_tdata[P_W-1:0];
      n0_r  <= NUM_W'(1);
      d0_r  <= '0;
      n1_r  <= NUM_W'(ipart);
      d1_r  <= LIM_W'(1);
    end
    if (state_r == ST_CMPD) begin
      d2_r <= mac_res[LIM_W-1:0];
    end
    if (state_r == ST_UPD) begin
      n0_r <= n1_r;
      n1_r <= mac_res[NUM_W-1:0];
      d0_r <= d1_r;
      d1_r <= d2_r;
      q_r  <= {1'b0, p_r};
      p_r  <= div_res.rem;
    end
    if (out_load) begin
      out_num_r <= n1_r;
      out_den_r <= d1_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_den_r, out_num_r};

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_den_r != '0))
    else $error("result denominator is zero");

  a_den_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (d1_r <= lim_r))
    else $error("working denominator exceeds limit");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == ST_DIV))
    else $error("divider finished outside of division state");

  a_cmp_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MULD) |=> (state_r == ST_CMPD))
    else $error("multiply not followed by compare");

endmodule

`default_nettype wire
